@@ sv/kfi_pkg.sv @@
// ----------------------------------------------------------------------------
// kfi_pkg
// shared types and constants of the keyframe scalar interpolator
// ----------------------------------------------------------------------------
`default_nettype none
package kfi_pkg;

  localparam int MAX_KEYS_DEF   = 64;
  localparam int FRAME_BITS_DEF = 24;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL,
    ST_MUL,
    ST_DIVS,
    ST_DIVW,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

@@ sv/kfi_cell.sv @@
// ----------------------------------------------------------------------------
// kfi_cell
// one key cell of the rotating key chain: holds a frame and a value
// ----------------------------------------------------------------------------
`default_nettype none
module kfi_cell #(
  parameter int FRAME_BITS = kfi_pkg::FRAME_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    load,
  input  wire logic                    shift,
  input  wire logic [FRAME_BITS-1:0]   load_frame,
  input  wire logic signed [15:0]      load_value,
  input  wire logic [FRAME_BITS-1:0]   nb_frame,
  input  wire logic signed [15:0]      nb_value,
  output logic [FRAME_BITS-1:0]        frame,
  output logic signed [15:0]           value
);

  always_ff @(posedge clk) begin
    if (shift) begin
      frame <= nb_frame;
      value <= nb_value;
    end else if (load) begin
      frame <= load_frame;
      value <= load_value;
    end
  end

endmodule
`default_nettype wire

@@ sv/kfi_divider.sv @@
// ----------------------------------------------------------------------------
// kfi_divider
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`default_nettype none
module kfi_divider #(
  parameter int NUM_W = 42,
  parameter int DEN_W = 25
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] dividend,
  input  wire logic signed [DEN_W-1:0] divisor,
  output kfi_pkg::div_status_t         status,
  output logic signed [NUM_W-1:0]      quotient
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [NUM_W-1:0] num_mag;
  logic [DEN_W-1:0] den_mag;
  logic [DEN_W:0]   rem;
  logic [NUM_W-1:0] quo;
  logic [CNT_W-1:0] cnt;
  logic             neg;
  logic             busy;
  logic             done;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;

  always_comb begin
    trial = {rem[DEN_W-1:0], num_mag[NUM_W-1]};
    diff  = trial - {1'b0, den_mag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_mag <= dividend[NUM_W-1] ? NUM_W'(-dividend) : NUM_W'(dividend);
      den_mag <= divisor[DEN_W-1] ? DEN_W'(-divisor) : DEN_W'(divisor);
      neg     <= dividend[NUM_W-1] ^ divisor[DEN_W-1];
      rem     <= '0;
      quo     <= '0;
    end else if (busy) begin
      num_mag <= {num_mag[NUM_W-2:0], 1'b0};
      if (!diff[DEN_W]) begin
        rem <= diff;
        quo <= {quo[NUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NUM_W-2:0], 1'b0};
      end
    end
  end

  assign quotient    = neg ? $signed(-quo) : $signed(quo);
  assign status.busy = busy;
  assign status.done = done;

endmodule
`default_nettype wire

@@ sv/keyframe_scalar_interpolator.sv @@
// ----------------------------------------------------------------------------
// keyframe_scalar_interpolator
// keyframe table with linear interpolation of a signed q2.14 value
// ----------------------------------------------------------------------------
// a key write is taken while idle; a query on an empty table goes straight to
//   finish, otherwise the key chain rotates through one full scan, then eval,
//   then a multiply and the divider when the result is interpolated, then
//   finish
// throughput: one query at a time, set by the key chain rotation and the
//   bit-serial divider; writes are taken every cycle while idle
// reset: rst clears the control state and key_count; key cells are not reset
`default_nettype none
module keyframe_scalar_interpolator #(
  parameter int MAX_KEYS   = kfi_pkg::MAX_KEYS_DEF,
  parameter int FRAME_BITS = kfi_pkg::FRAME_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration channel
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [6:0]            key_count,
  // input transaction
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  cmd,
  input  wire logic [5:0]            key_index,
  input  wire logic [FRAME_BITS-1:0] key_frame,
  input  wire logic signed [15:0]    key_value,
  input  wire logic [FRAME_BITS-1:0] query_frame,
  // result transaction
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic signed [15:0]         interp_value,
  output logic [5:0]                 segment_index,
  output logic                       used_default
);

  localparam int KW    = (MAX_KEYS > 2) ? $clog2(MAX_KEYS) : 1;
  localparam int CW    = $clog2(MAX_KEYS + 1);
  localparam int OFF_W = FRAME_BITS + 1;
  localparam int NUM_W = OFF_W + 17;
  localparam int SUM_W = NUM_W + 1;

  // configuration register, always ready
  logic [6:0] kc;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) kc <= '0;
    else if (cfg_valid) kc <= key_count;
  end

  kfi_pkg::state_t state, state_next;

  logic in_acc;
  logic rotate;
  logic div_start;
  assign in_acc = in_valid && in_ready;

  // key chain: cell i takes from cell i+1, the last cell takes from cell 0,
  // so the head (cell 0) streams entry k at scan step k and after MAX_KEYS
  // shifts every entry is back in its home cell
  logic [FRAME_BITS-1:0] cell_frame [MAX_KEYS];
  logic signed [15:0]    cell_value [MAX_KEYS];

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    logic wr;
    assign wr = in_acc && (cmd == kfi_pkg::CMD_WRITE) && (32'(key_index) == i);
    kfi_cell #(.FRAME_BITS(FRAME_BITS)) u_cell (
      .clk       (clk),
      .load      (wr),
      .shift     (rotate),
      .load_frame(key_frame),
      .load_value(key_value),
      .nb_frame  (cell_frame[(i + 1) % MAX_KEYS]),
      .nb_value  (cell_value[(i + 1) % MAX_KEYS]),
      .frame     (cell_frame[i]),
      .value     (cell_value[i])
    );
  end

  logic [FRAME_BITS-1:0] head_frame;
  logic signed [15:0]    head_value;
  assign head_frame = cell_frame[0];
  assign head_value = cell_value[0];

  // scan and segment registers
  logic [KW-1:0]         k;
  logic [CW-1:0]         count;
  logic [FRAME_BITS-1:0] qf;
  logic                  found;
  logic                  need_next;
  logic [KW-1:0]         p;
  logic [FRAME_BITS-1:0] f1, f2, prevf;
  logic signed [15:0]    v1, v2, prevv, lastv;
  logic signed [16:0]    dv;
  logic signed [OFF_W-1:0] off;
  logic signed [OFF_W-1:0] span;
  logic signed [NUM_W-1:0] prod;
  logic signed [NUM_W-1:0] quo;
  kfi_pkg::div_status_t    dstat;

  logic                  step;
  logic                  scan_last;
  logic [31:0]           cnt_sat;
  assign step      = (CW'(k) < count);
  assign scan_last = (32'(k) == MAX_KEYS - 1);
  assign cnt_sat   = (32'(kc) > 32'(MAX_KEYS)) ? 32'(MAX_KEYS) : 32'(kc);

  // eval decision
  logic                    take_last;
  logic signed [OFF_W-1:0] span_c;
  assign take_last = !found || (32'(p) + 32'd2 > 32'(count));
  assign span_c    = $signed({1'b0, f2}) - $signed({1'b0, f1});

  // final sum and saturation
  logic signed [SUM_W-1:0] sum;
  logic signed [15:0]      sat;
  assign sum = SUM_W'(quo) + SUM_W'(v1);
  always_comb begin
    if (sum > $signed(SUM_W'(32767)))       sat = 16'sh7fff;
    else if (sum < $signed(-SUM_W'(32768))) sat = 16'sh8000;
    else                                    sat = 16'(sum);
  end

  kfi_divider #(.NUM_W(NUM_W), .DEN_W(OFF_W)) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(prod),
    .divisor (span),
    .status  (dstat),
    .quotient(quo)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      kfi_pkg::ST_IDLE:
        if (in_acc && cmd == kfi_pkg::CMD_QUERY)
          state_next = (cnt_sat == 32'd0) ? kfi_pkg::ST_FINISH : kfi_pkg::ST_SCAN;
      kfi_pkg::ST_SCAN: if (scan_last) state_next = kfi_pkg::ST_EVAL;
      kfi_pkg::ST_EVAL:
        if (take_last || span_c == '0) state_next = kfi_pkg::ST_FINISH;
        else                           state_next = kfi_pkg::ST_MUL;
      kfi_pkg::ST_MUL:  state_next = kfi_pkg::ST_DIVS;
      kfi_pkg::ST_DIVS: state_next = kfi_pkg::ST_DIVW;
      kfi_pkg::ST_DIVW: if (dstat.done) state_next = kfi_pkg::ST_FINISH;
      kfi_pkg::ST_FINISH: if (!out_valid || out_ready) state_next = kfi_pkg::ST_IDLE;
      default: state_next = kfi_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    rotate    = 1'b0;
    div_start = 1'b0;
    case (state)
      kfi_pkg::ST_IDLE: in_ready  = 1'b1;
      kfi_pkg::ST_SCAN: rotate    = 1'b1;
      kfi_pkg::ST_DIVS: div_start = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= kfi_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // result staging
  logic signed [15:0] res;
  logic [KW-1:0]      seg;
  logic               dflt;

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      kfi_pkg::ST_IDLE: begin
        k         <= '0;
        found     <= 1'b0;
        need_next <= 1'b0;
        qf        <= query_frame;
        count     <= CW'(cnt_sat);
        res       <= kfi_pkg::ONE_Q14;
        seg       <= '0;
        dflt      <= 1'b1;
      end
      kfi_pkg::ST_SCAN: begin
        k <= k + 1'b1;
        if (step) begin
          prevf <= head_frame;
          prevv <= head_value;
          if (CW'(k) == count - 1'b1) lastv <= head_value;
          if (!found && head_frame > qf) begin
            found <= 1'b1;
            if (k == '0) begin
              p         <= '0;
              f1        <= head_frame;
              v1        <= head_value;
              need_next <= 1'b1;
            end else begin
              p  <= k - 1'b1;
              f1 <= prevf;
              v1 <= prevv;
              f2 <= head_frame;
              v2 <= head_value;
            end
          end
          if (need_next && k == KW'(1)) begin
            f2        <= head_frame;
            v2        <= head_value;
            need_next <= 1'b0;
          end
        end
      end
      kfi_pkg::ST_EVAL: begin
        dflt <= 1'b0;
        seg  <= found ? p : KW'(count - 1'b1);
        span <= span_c;
        off  <= $signed({1'b0, qf}) - $signed({1'b0, f1});
        dv   <= $signed({v2[15], v2}) - $signed({v1[15], v1});
        if (take_last)          res <= lastv;
        else if (span_c == '0)  res <= v2;
      end
      kfi_pkg::ST_MUL: prod <= NUM_W'(dv) * NUM_W'(off);
      kfi_pkg::ST_DIVW: if (dstat.done) res <= sat;
      default: ;
    endcase
  end

  // output register, parts the result side from the input side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == kfi_pkg::ST_FINISH && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == kfi_pkg::ST_FINISH && (!out_valid || out_ready)) begin
      interp_value  <= res;
      segment_index <= 6'(seg);
      used_default  <= dflt;
    end
  end

endmodule
`default_nettype wire
